// File: design/ctk_pkg.sv
package ctk_pkg;

	// default sizes
	localparam int KEYWORD_CHARS_DEF = 8;
	localparam int OFFSET_BITS_DEF   = 24;
	localparam int LINE_BITS_DEF     = 20;
	localparam int LENGTH_BITS_DEF   = 16;

	localparam int KIND_BITS = 6;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// token kinds
	localparam logic [KIND_BITS-1:0] KIND_EOF      = 6'd0;
	localparam logic [KIND_BITS-1:0] KIND_IDENT    = 6'd1;
	localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 6'd2;
	localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 6'd3;
	localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 6'd4;
	localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 6'd5;
	localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 6'd6;
	localparam logic [KIND_BITS-1:0] KIND_LBRACKET = 6'd7;
	localparam logic [KIND_BITS-1:0] KIND_RBRACKET = 6'd8;
	localparam logic [KIND_BITS-1:0] KIND_SEMI     = 6'd9;
	localparam logic [KIND_BITS-1:0] KIND_COMMA    = 6'd10;
	localparam logic [KIND_BITS-1:0] KIND_STAR     = 6'd11;
	localparam logic [KIND_BITS-1:0] KIND_TYPEDEF  = 6'd12;
	localparam logic [KIND_BITS-1:0] KIND_STRUCT   = 6'd13;
	localparam logic [KIND_BITS-1:0] KIND_UNION    = 6'd14;
	localparam logic [KIND_BITS-1:0] KIND_ENUM     = 6'd15;
	localparam logic [KIND_BITS-1:0] KIND_CONST    = 6'd16;
	localparam logic [KIND_BITS-1:0] KIND_UNSIGNED = 6'd17;
	localparam logic [KIND_BITS-1:0] KIND_SIGNED   = 6'd18;
	localparam logic [KIND_BITS-1:0] KIND_VOID     = 6'd19;
	localparam logic [KIND_BITS-1:0] KIND_CHAR     = 6'd20;
	localparam logic [KIND_BITS-1:0] KIND_SHORT    = 6'd21;
	localparam logic [KIND_BITS-1:0] KIND_INT      = 6'd22;
	localparam logic [KIND_BITS-1:0] KIND_LONG     = 6'd23;
	localparam logic [KIND_BITS-1:0] KIND_FLOAT    = 6'd24;
	localparam logic [KIND_BITS-1:0] KIND_DOUBLE   = 6'd25;
	localparam logic [KIND_BITS-1:0] KIND_INT8     = 6'd26;
	localparam logic [KIND_BITS-1:0] KIND_UINT8    = 6'd27;
	localparam logic [KIND_BITS-1:0] KIND_INT16    = 6'd28;
	localparam logic [KIND_BITS-1:0] KIND_UINT16   = 6'd29;
	localparam logic [KIND_BITS-1:0] KIND_INT32    = 6'd30;
	localparam logic [KIND_BITS-1:0] KIND_UINT32   = 6'd31;
	localparam logic [KIND_BITS-1:0] KIND_INT64    = 6'd32;
	localparam logic [KIND_BITS-1:0] KIND_UINT64   = 6'd33;

	// special characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_SLASH,
		MODE_LINECMT,
		MODE_BLOCK,
		MODE_BLOCKSTAR
	} mode_t;

	typedef struct packed {
		logic hit;
		logic [KIND_BITS-1:0] kind;
		logic cstr;
	} kw_hit_t;

	// queue write strobes: second implies first
	typedef struct packed {
		logic v0;
		logic v1;
	} push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
		logic [KIND_BITS-1:0] k;
		case (c)
			"{":     k = KIND_LBRACE;
			"}":     k = KIND_RBRACE;
			"(":     k = KIND_LPAREN;
			")":     k = KIND_RPAREN;
			"[":     k = KIND_LBRACKET;
			"]":     k = KIND_RBRACKET;
			";":     k = KIND_SEMI;
			",":     k = KIND_COMMA;
			"*":     k = KIND_STAR;
			default: k = KIND_EOF;
		endcase
		return k;
	endfunction

	// key: first char in the top byte, zero padded at the bottom
	function automatic kw_hit_t kw_lookup(input logic [63:0] key);
		kw_hit_t r;
		r.hit  = 1'b1;
		r.cstr = 1'b0;
		unique case (key)
			{"typedef", 8'h00}:  r.kind = KIND_TYPEDEF;
			{"struct", 16'h0}:   r.kind = KIND_STRUCT;
			{"union", 24'h0}:    r.kind = KIND_UNION;
			{"enum", 32'h0}:     r.kind = KIND_ENUM;
			{"const", 24'h0}:    r.kind = KIND_CONST;
			{"unsigned"}:        r.kind = KIND_UNSIGNED;
			{"signed", 16'h0}:   r.kind = KIND_SIGNED;
			{"void", 32'h0}:     r.kind = KIND_VOID;
			{"char", 32'h0}:     r.kind = KIND_CHAR;
			{"short", 24'h0}:    r.kind = KIND_SHORT;
			{"int", 40'h0}:      r.kind = KIND_INT;
			{"long", 32'h0}:     r.kind = KIND_LONG;
			{"float", 24'h0}:    r.kind = KIND_FLOAT;
			{"double", 16'h0}:   r.kind = KIND_DOUBLE;
			{"int8_t", 16'h0}:   r.kind = KIND_INT8;
			{"uint8_t", 8'h00}:  r.kind = KIND_UINT8;
			{"int16_t", 8'h00}:  r.kind = KIND_INT16;
			{"uint16", "_t"}:    r.kind = KIND_UINT16;
			{"int32_t", 8'h00}:  r.kind = KIND_INT32;
			{"uint32", "_t"}:    r.kind = KIND_UINT32;
			{"int64_t", 8'h00}:  r.kind = KIND_INT64;
			{"uint64", "_t"}:    r.kind = KIND_UINT64;
			{"size_t", 16'h0}:   r.kind = KIND_UINT64;
			{"ssize_t", 8'h00}:  r.kind = KIND_INT64;
			{"DWORD", 24'h0}:    r.kind = KIND_UINT32;
			{"WORD", 32'h0}:     r.kind = KIND_UINT16;
			{"BYTE", 32'h0}:     r.kind = KIND_UINT8;
			{"BOOL", 32'h0}:     r.kind = KIND_INT32;
			{"HANDLE", 16'h0}:   r.kind = KIND_UINT64;
			{"LPVOID", 16'h0}:   r.kind = KIND_UINT64;
			{"LPCSTR", 16'h0}: begin
				r.kind = KIND_IDENT;
				r.cstr = 1'b1;
			end
			{"LPSTR", 24'h0}: begin
				r.kind = KIND_IDENT;
				r.cstr = 1'b1;
			end
			default: begin
				r.hit  = 1'b0;
				r.kind = KIND_IDENT;
			end
		endcase
		return r;
	endfunction

endpackage

// File: design/ctk_lexer.sv
module ctk_lexer import ctk_pkg::*; #(
	parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
	parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
	parameter int LINE_BITS     = LINE_BITS_DEF,
	parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
	parameter int TDATA_W       = 72
) (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [7:0] char_byte,
	input  logic end_flag,
	output push_t push,
	output logic [TDATA_W+1:0] d0,
	output logic [TDATA_W+1:0] d1
);

	mode_t mode_q, mode_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [OFFSET_BITS-1:0] begin_q, begin_d;
	logic [LENGTH_BITS-1:0] chars_q, chars_d;
	logic [KEYWORD_CHARS-1:0][7:0] win_q, win_d;

	logic [63:0] key;
	logic hi_zero;
	kw_hit_t kw;
	logic [KIND_BITS-1:0] pend_kind, o_kind, pk;
	logic pend_cstr;
	logic [LENGTH_BITS-1:0] o_len;
	logic fin, emit_p, emit_o, idle_h, nl, add, start_t;
	mode_t start_mode;
	logic [TDATA_W-1:0] pend_data, o_data;

	// keyword key from the first eight window bytes
	always_comb begin
		key = '0;
		hi_zero = 1'b1;
		for (int i = 0; i < 8; i++) begin
			key[63-8*i -: 8] = win_q[i];
		end
		for (int i = 8; i < KEYWORD_CHARS; i++) begin
			if (win_q[i] != 8'h00) hi_zero = 1'b0;
		end
	end

	always_comb begin
		kw = kw_lookup(key);
		pend_kind = (mode_q == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
		pend_cstr = 1'b0;
		if (mode_q == MODE_IDENT && chars_q <= LENGTH_BITS'(KEYWORD_CHARS) && hi_zero
				&& kw.hit) begin
			pend_kind = kw.kind;
			pend_cstr = kw.cstr;
		end
		pk = punct_kind(char_byte);
		fin = end_flag || (char_byte == CH_NUL);

		mode_d = mode_q;
		line_d = line_q;
		off_d = off_q;
		begin_d = begin_q;
		chars_d = chars_q;
		win_d = win_q;
		emit_p = 1'b0;
		emit_o = 1'b0;
		o_kind = KIND_EOF;
		o_len = '0;
		idle_h = 1'b0;
		nl = 1'b0;
		add = 1'b0;
		start_t = 1'b0;
		start_mode = MODE_IDLE;

		if (fin) begin
			emit_p = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
			emit_o = 1'b1;
			mode_d = MODE_IDLE;
			line_d = LINE_BITS'(1);
			off_d = '0;
			begin_d = '0;
			chars_d = '0;
			win_d = '0;
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					if (is_alpha(char_byte) || is_digit(char_byte)) begin
						add = 1'b1;
					end else begin
						emit_p = 1'b1;
						mode_d = MODE_IDLE;
						idle_h = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(char_byte)) begin
						add = 1'b1;
					end else begin
						emit_p = 1'b1;
						mode_d = MODE_IDLE;
						idle_h = 1'b1;
					end
				end
				MODE_SLASH: begin
					if (char_byte == CH_SLASH) mode_d = MODE_LINECMT;
					else if (char_byte == CH_STAR) mode_d = MODE_BLOCK;
					else begin
						mode_d = MODE_IDLE;
						idle_h = 1'b1;
					end
				end
				MODE_LINECMT: begin
					if (char_byte == CH_NL) begin
						mode_d = MODE_IDLE;
						idle_h = 1'b1;
					end
				end
				MODE_BLOCK: begin
					if (char_byte == CH_STAR) mode_d = MODE_BLOCKSTAR;
					else if (char_byte == CH_NL) nl = 1'b1;
				end
				MODE_BLOCKSTAR: begin
					if (char_byte == CH_SLASH) mode_d = MODE_IDLE;
					else if (char_byte != CH_STAR) begin
						mode_d = MODE_BLOCK;
						nl = (char_byte == CH_NL);
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					idle_h = 1'b1;
				end
			endcase

			if (idle_h) begin
				if (char_byte == CH_NL) nl = 1'b1;
				else if (char_byte == CH_SLASH) mode_d = MODE_SLASH;
				else if (pk != KIND_EOF) begin
					emit_o = 1'b1;
					o_kind = pk;
					o_len = LENGTH_BITS'(1);
				end else if (is_digit(char_byte)) begin
					start_t = 1'b1;
					start_mode = MODE_NUMBER;
				end else if (is_alpha(char_byte)) begin
					start_t = 1'b1;
					start_mode = MODE_IDENT;
				end
			end

			if (nl && line_q != '1) line_d = line_q + LINE_BITS'(1);

			if (add) begin
				for (int i = 0; i < KEYWORD_CHARS; i++) begin
					if (chars_q == LENGTH_BITS'(i)) win_d[i] = char_byte;
				end
				if (chars_q != '1) chars_d = chars_q + LENGTH_BITS'(1);
			end

			if (start_t) begin
				mode_d = start_mode;
				begin_d = off_q;
				chars_d = LENGTH_BITS'(1);
				win_d = '0;
				win_d[0] = char_byte;
			end

			if (off_q != '1) off_d = off_q + OFFSET_BITS'(1);
		end
	end

	// tdata: kind, line, start, length from the low bit up
	assign pend_data = TDATA_W'({chars_q, begin_q, line_q, pend_kind});
	assign o_data    = TDATA_W'({o_len, off_q, line_q, o_kind});

	// pending token goes first, punctuator or end token after it
	always_comb begin
		push.v0 = go && (emit_p || emit_o);
		push.v1 = go && emit_p && emit_o;
		if (emit_p) d0 = {!emit_o, pend_cstr, pend_data};
		else d0 = {1'b1, 1'b0, o_data};
		d1 = {1'b1, 1'b0, o_data};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= LINE_BITS'(1);
			off_q <= '0;
			begin_q <= '0;
			chars_q <= '0;
			win_q <= '0;
		end else if (go) begin
			mode_q <= mode_d;
			line_q <= line_d;
			off_q <= off_d;
			begin_q <= begin_d;
			chars_q <= chars_d;
			win_q <= win_d;
		end
	end

endmodule

// File: design/ctk_result_fifo.sv
module ctk_result_fifo import ctk_pkg::*; #(
	parameter int TDATA_W = 72
) (
	input  logic clk,
	input  logic arst_n,
	input  push_t push,
	input  logic [TDATA_W+1:0] d0,
	input  logic [TDATA_W+1:0] d1,
	output logic room,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic m_tuser,
	output logic m_tlast
);

	logic [FIFO_DEPTH-1:0][TDATA_W+1:0] mem_q;
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic pop;
	logic [FIFO_CNT_W-1:0] n_push;

	assign pop = m_tvalid && m_tready;
	assign n_push = FIFO_CNT_W'(push.v0) + FIFO_CNT_W'(push.v1);
	// room for a two-result request
	assign room = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign m_tvalid = count_q != '0;
	assign {m_tlast, m_tuser, m_tdata} = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.v0) mem_q[wr_q] <= d0;
		if (push.v1) mem_q[wr_q + FIFO_PTR_W'(1)] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + FIFO_PTR_W'(n_push);
			if (pop) rd_q <= rd_q + FIFO_PTR_W'(1);
			count_q <= count_q + n_push - FIFO_CNT_W'(pop);
		end
	end

endmodule

// File: design/c_declaration_tokenizer.sv
// Byte-serial C declaration tokenizer.
// A byte accepted on s_* lands in the input register, is scanned from there, and its tokens
// go through the result queue to m_*. Throughput: one byte per cycle while the 4-deep queue
// has room for two requests; a byte that closes a token and is itself a token (or the end
// of text) makes two requests, which drain one per cycle while m_tready is high.
// Reset (arst_n low, asynchronous): idle scanner, line 1, offset 0, queue empty.
module c_declaration_tokenizer import ctk_pkg::*; #(
	parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
	parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
	parameter int LINE_BITS     = LINE_BITS_DEF,
	parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
	localparam int TDATA_W = ((KIND_BITS + LINE_BITS + OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,          // char_byte
	input  logic s_tlast,                // end_of_input
	output logic m_tvalid,
	input  logic m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // token_kind, token_line, token_start, token_length
	output logic m_tuser,                // cstr_alias
	output logic m_tlast                 // last_of_run
);

	// input register
	logic valid_s1;
	logic [7:0] char_s1;
	logic last_s1;

	logic room, go;
	push_t push;
	logic [TDATA_W+1:0] d0, d1;

	// scan the held byte when the queue can take two requests
	assign go = valid_s1 && room;
	// the input register refills in the same cycle it is scanned
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// scanner state and token build-up
	ctk_lexer #(
		.KEYWORD_CHARS(KEYWORD_CHARS),
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS(LINE_BITS),
		.LENGTH_BITS(LENGTH_BITS),
		.TDATA_W(TDATA_W)
	) u_lexer (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.char_byte(char_s1),
		.end_flag(last_s1),
		.push(push),
		.d0(d0),
		.d1(d1)
	);

	// result queue parts scanner from the output handshake
	ctk_result_fifo #(
		.TDATA_W(TDATA_W)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.d0(d0),
		.d1(d1),
		.room(room),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule
